[src/segi_pkg.sv]
package segi_pkg;

	localparam int COORD_W = 16;
	localparam int FRAC_W  = 8;
	localparam int OUT_W   = COORD_W + FRAC_W;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int SIDE_W  = PROD_W + 1;
	localparam int DEN_W   = PROD_W + 2;
	localparam int PMUL_W  = DEN_W + DIFF_W;
	localparam int QUO_W   = COORD_W + FRAC_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_start_x;
		logic signed [COORD_W-1:0] first_start_y;
		logic signed [COORD_W-1:0] first_end_x;
		logic signed [COORD_W-1:0] first_end_y;
		logic signed [COORD_W-1:0] second_start_x;
		logic signed [COORD_W-1:0] second_start_y;
		logic signed [COORD_W-1:0] second_end_x;
		logic signed [COORD_W-1:0] second_end_y;
	} seg_pair_t;

	typedef struct packed {
		logic                    crosses;
		logic signed [OUT_W-1:0] cross_x;
		logic signed [OUT_W-1:0] cross_y;
	} cross_res_t;

	// front end to dividers
	typedef struct packed {
		logic                      valid;
		logic                      keep;
		logic [DEN_W-1:0]          den;
		logic signed [PMUL_W-1:0]  px;
		logic signed [PMUL_W-1:0]  py;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
	} geo_t;

endpackage

[src/segi_front.sv]
module segi_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  segi_pkg::seg_pair_t in_item,
	output segi_pkg::geo_t      geo
);
	localparam int C  = segi_pkg::COORD_W;
	localparam int E  = segi_pkg::DIFF_W;
	localparam int M  = segi_pkg::PROD_W;
	localparam int S  = segi_pkg::SIDE_W;
	localparam int D  = segi_pkg::DEN_W;
	localparam int PW = segi_pkg::PMUL_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1: differences
	logic signed [E-1:0] rx_s1, ry_s1, sx_s1, sy_s1, acx_s1, acy_s1, adx_s1, ady_s1;
	logic signed [E-1:0] cax_s1, cay_s1, cbx_s1, cby_s1;
	logic signed [C-1:0] ax_s1, ay_s1;

	always_ff @(posedge clk) begin
		rx_s1  <= E'(in_item.first_end_x) - E'(in_item.first_start_x);
		ry_s1  <= E'(in_item.first_end_y) - E'(in_item.first_start_y);
		sx_s1  <= E'(in_item.second_end_x) - E'(in_item.second_start_x);
		sy_s1  <= E'(in_item.second_end_y) - E'(in_item.second_start_y);
		acx_s1 <= E'(in_item.second_start_x) - E'(in_item.first_start_x);
		acy_s1 <= E'(in_item.second_start_y) - E'(in_item.first_start_y);
		adx_s1 <= E'(in_item.second_end_x) - E'(in_item.first_start_x);
		ady_s1 <= E'(in_item.second_end_y) - E'(in_item.first_start_y);
		cax_s1 <= E'(in_item.first_start_x) - E'(in_item.second_start_x);
		cay_s1 <= E'(in_item.first_start_y) - E'(in_item.second_start_y);
		cbx_s1 <= E'(in_item.first_end_x) - E'(in_item.second_start_x);
		cby_s1 <= E'(in_item.first_end_y) - E'(in_item.second_start_y);
		ax_s1  <= in_item.first_start_x;
		ay_s1  <= in_item.first_start_y;
	end

	// stage 2: products
	logic signed [M-1:0] p1a_s2, p1b_s2, p2a_s2, p2b_s2, p3a_s2, p3b_s2, p4a_s2, p4b_s2;
	logic signed [M-1:0] pda_s2, pdb_s2, pna_s2, pnb_s2;
	logic signed [E-1:0] rx_s2, ry_s2;
	logic signed [C-1:0] ax_s2, ay_s2;

	always_ff @(posedge clk) begin
		p1a_s2 <= rx_s1 * acy_s1;
		p1b_s2 <= ry_s1 * acx_s1;
		p2a_s2 <= rx_s1 * ady_s1;
		p2b_s2 <= ry_s1 * adx_s1;
		p3a_s2 <= sx_s1 * cay_s1;
		p3b_s2 <= sy_s1 * cax_s1;
		p4a_s2 <= sx_s1 * cby_s1;
		p4b_s2 <= sy_s1 * cbx_s1;
		pda_s2 <= rx_s1 * sy_s1;
		pdb_s2 <= ry_s1 * sx_s1;
		pna_s2 <= acx_s1 * sy_s1;
		pnb_s2 <= acy_s1 * sx_s1;
		rx_s2  <= rx_s1;
		ry_s2  <= ry_s1;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
	end

	// stage 3: side tests, denominator and numerator
	logic signed [S-1:0] sd1_s3, sd2_s3, sd3_s3, sd4_s3;
	logic signed [D-1:0] den_s3, num_s3;
	logic signed [E-1:0] rx_s3, ry_s3;
	logic signed [C-1:0] ax_s3, ay_s3;

	always_ff @(posedge clk) begin
		sd1_s3 <= S'(p1a_s2) - S'(p1b_s2);
		sd2_s3 <= S'(p2a_s2) - S'(p2b_s2);
		sd3_s3 <= S'(p3a_s2) - S'(p3b_s2);
		sd4_s3 <= S'(p4a_s2) - S'(p4b_s2);
		den_s3 <= D'(pda_s2) - D'(pdb_s2);
		num_s3 <= D'(pna_s2) - D'(pnb_s2);
		rx_s3  <= rx_s2;
		ry_s3  <= ry_s2;
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
	end

	// stage 4: strict opposite sides, make the denominator positive
	logic                opp_a, opp_b;
	logic signed [D-1:0] dn, nn;
	logic signed [D-1:0] den_s4, num_s4;
	logic                keep_s4;
	logic signed [E-1:0] rx_s4, ry_s4;
	logic signed [C-1:0] ax_s4, ay_s4;

	always_comb begin
		opp_a = (|sd1_s3) && (|sd2_s3) && (sd1_s3[S-1] ^ sd2_s3[S-1]);
		opp_b = (|sd3_s3) && (|sd4_s3) && (sd3_s3[S-1] ^ sd4_s3[S-1]);
		dn = den_s3[D-1] ? -den_s3 : den_s3;
		nn = den_s3[D-1] ? -num_s3 : num_s3;
	end

	always_ff @(posedge clk) begin
		keep_s4 <= opp_a && opp_b && (dn != '0) && (nn > 0) && (nn < dn);
		den_s4  <= dn;
		num_s4  <= nn;
		rx_s4   <= rx_s3;
		ry_s4   <= ry_s3;
		ax_s4   <= ax_s3;
		ay_s4   <= ay_s3;
	end

	// stage 5: scale both deltas by the numerator
	logic                 keep_s5;
	logic [D-1:0]         den_s5;
	logic signed [PW-1:0] px_s5, py_s5;
	logic signed [C-1:0]  ax_s5, ay_s5;

	always_ff @(posedge clk) begin
		keep_s5 <= keep_s4;
		den_s5  <= den_s4;
		px_s5   <= PW'(num_s4) * PW'(rx_s4);
		py_s5   <= PW'(num_s4) * PW'(ry_s4);
		ax_s5   <= ax_s4;
		ay_s5   <= ay_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign geo = '{valid: v_s5, keep: keep_s5, den: den_s5, px: px_s5, py: py_s5,
		ax: ax_s5, ay: ay_s5};

endmodule

[src/segi_div.sv]
module segi_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_keep,
	input  logic signed [segi_pkg::COORD_W-1:0]   in_base,
	input  logic signed [segi_pkg::PMUL_W-1:0]    in_prod,
	input  logic [segi_pkg::DEN_W-1:0]            in_den,
	output logic                                  out_valid,
	output logic                                  out_keep,
	output logic signed [segi_pkg::OUT_W-1:0]     out_value
);
	localparam int C  = segi_pkg::COORD_W;
	localparam int F  = segi_pkg::FRAC_W;
	localparam int D  = segi_pkg::DEN_W;
	localparam int PW = segi_pkg::PMUL_W;
	localparam int Q  = segi_pkg::QUO_W;
	localparam int OW = segi_pkg::OUT_W;
	localparam int XW = OW + 2;

	logic          valid_s [Q+1];
	logic          keep_s  [Q+1];
	logic          neg_s   [Q+1];
	logic [C-1:0]  base_s  [Q+1];
	logic [D-1:0]  den_s   [Q+1];
	logic [D-1:0]  rem_s   [Q+1];
	logic [Q-1:0]  dlo_s   [Q+1];
	logic [Q-1:0]  quo_s   [Q+1];
	logic [PW-1:0] mag;

	assign mag = in_prod[PW-1] ? PW'(-in_prod) : PW'(in_prod);

	// entry: top part of the dividend seeds the remainder, it is below the divisor
	always_ff @(posedge clk) begin
		keep_s[0] <= in_keep;
		neg_s[0]  <= in_prod[PW-1];
		base_s[0] <= in_base;
		den_s[0]  <= in_den;
		rem_s[0]  <= D'(mag >> C);
		dlo_s[0]  <= Q'(mag[C-1:0]) << F;
		quo_s[0]  <= '0;
	end

	genvar k;
	generate
		for (k = 1; k <= Q; k++) begin : g_step
			logic [D:0] trial;
			logic       ge;
			always_comb begin
				trial = {rem_s[k-1], dlo_s[k-1][Q-k]};
				ge    = trial >= {1'b0, den_s[k-1]};
			end
			always_ff @(posedge clk) begin
				keep_s[k] <= keep_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				base_s[k] <= base_s[k-1];
				den_s[k]  <= den_s[k-1];
				dlo_s[k]  <= dlo_s[k-1];
				rem_s[k]  <= ge ? D'(trial - {1'b0, den_s[k-1]}) : D'(trial);
				quo_s[k]  <= {quo_s[k-1][Q-2:0], ge};
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
			out_valid  <= valid_s[Q];
		end
	end

	// floor of the scaled offset, add the base, then round toward zero
	logic                 inexact;
	logic signed [XW-1:0] fl_v, fl_t, base_x;

	always_comb begin
		inexact = |rem_s[Q];
		base_x  = XW'($signed(base_s[Q])) <<< F;
		if (neg_s[Q])
			fl_v = -$signed({2'b00, quo_s[Q]}) - $signed(XW'(inexact));
		else
			fl_v = $signed({2'b00, quo_s[Q]});
		fl_t = base_x + fl_v;
		if (inexact && fl_t[XW-1])
			fl_t = fl_t + XW'(1);
	end

	always_ff @(posedge clk) begin
		out_keep  <= keep_s[Q];
		out_value <= keep_s[Q] ? OW'(fl_t) : '0;
	end

endmodule

[src/segment_intersection_top.sv]
// Pipeline: 31 register stages lie between the edge that accepts an item and the result strobe
// (5 geometry stages, the divider entry, one stage per quotient bit, exit).
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset: arst_n clears every valid bit at once; data registers are not reset.
module segment_intersection_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  segi_pkg::seg_pair_t  item,
	output logic                 done,
	output segi_pkg::cross_res_t result
);
	segi_pkg::geo_t geo;
	logic           xv, yv, xk, yk;
	logic signed [segi_pkg::OUT_W-1:0] xo, yo;

	assign busy = 1'b0;

	segi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_item  (item),
		.geo      (geo)
	);

	segi_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geo.valid),
		.in_keep   (geo.keep),
		.in_base   (geo.ax),
		.in_prod   (geo.px),
		.in_den    (geo.den),
		.out_valid (xv),
		.out_keep  (xk),
		.out_value (xo)
	);

	segi_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geo.valid),
		.in_keep   (geo.keep),
		.in_base   (geo.ay),
		.in_prod   (geo.py),
		.in_den    (geo.den),
		.out_valid (yv),
		.out_keep  (yk),
		.out_value (yo)
	);

	assign done           = xv;
	assign result.crosses = xk;
	assign result.cross_x = xo;
	assign result.cross_y = yo;

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(xv == yv) && (!xv || xk == yk))
		else $error("divider lanes out of step");

	a_no_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.crosses |-> result.cross_x == '0 && result.cross_y == '0)
		else $error("coordinates not cleared without a crossing");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 31))
		else $error("result without an item 31 cycles earlier");

endmodule
